// File: hdl/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, codes and step table of the six-step commutation sequencer.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned StepW   = 3;
  localparam int unsigned ActionW = 4;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned MetricW = 8;

  localparam logic [MetricW-1:0] MetricFloor = 8'd120;
  localparam logic [StepW-1:0]   FirstStep   = 3'd1;

  // operation codes of an input item
  localparam logic OpBegin = 1'b0;
  localparam logic OpEvent = 1'b1;

  // action codes
  localparam logic [ActionW-1:0] ActWaitPreScan = 4'd0;
  localparam logic [ActionW-1:0] ActStartAdc    = 4'd1;
  localparam logic [ActionW-1:0] ActWaitCmpHigh = 4'd2;
  localparam logic [ActionW-1:0] ActWaitCmpLow  = 4'd3;
  localparam logic [ActionW-1:0] ActIntegrity   = 4'd4;
  localparam logic [ActionW-1:0] ActRpmLimit    = 4'd5;
  localparam logic [ActionW-1:0] ActWaitComm    = 4'd6;
  localparam logic [ActionW-1:0] ActCommutate   = 4'd7;
  localparam logic [ActionW-1:0] ActTempCheck   = 4'd8;
  localparam logic [ActionW-1:0] ActNextTiming  = 4'd9;
  localparam logic [ActionW-1:0] ActRun6Start   = 4'd10;
  localparam logic [ActionW-1:0] ActRun6Init    = 4'd11;
  localparam logic [ActionW-1:0] ActRun6Stop    = 4'd12;

  typedef enum logic [1:0] {
    ResCommutated = 2'd0,
    ResSyncLost   = 2'd1,
    ResRunBegun   = 2'd2
  } run_result_e;

  typedef struct packed {
    logic [PhaseW-1:0] power;
    logic [PhaseW-1:0] pwm;
    logic [PhaseW-1:0] sense;
    logic              rising;
    logic [StepW-1:0]  next;
    logic              adc;
    logic              rpm;
    logic              temp;
    logic              run6;
  } step_row_t;

  // one classified item handed from front to back
  typedef struct packed {
    run_result_e        kind;
    logic [StepW-1:0]   cur_step;
    logic [StepW-1:0]   follow_step;
    logic [MetricW-1:0] level;
  } job_t;

  function automatic step_row_t step_row_f(input logic [StepW-1:0] step);
    step_row_t r;
    case (step)
      3'd2:    r = '{2'd0, 2'd2, 2'd1, 1'b0, 3'd3, 1'b0, 1'b1, 1'b0, 1'b0};
      3'd3:    r = '{2'd0, 2'd1, 2'd2, 1'b1, 3'd4, 1'b0, 1'b0, 1'b0, 1'b0};
      3'd4:    r = '{2'd2, 2'd1, 2'd0, 1'b0, 3'd5, 1'b0, 1'b0, 1'b0, 1'b0};
      3'd5:    r = '{2'd2, 2'd0, 2'd1, 1'b1, 3'd6, 1'b0, 1'b0, 1'b0, 1'b0};
      3'd6:    r = '{2'd1, 2'd0, 2'd2, 1'b0, 3'd1, 1'b1, 1'b0, 1'b1, 1'b1};
      default: r = '{2'd1, 2'd2, 2'd0, 1'b1, 3'd2, 1'b0, 1'b0, 1'b0, 1'b0};
    endcase
    return r;
  endfunction

  // action that follows act in the run of a step
  function automatic logic [ActionW-1:0] next_action_f(input logic [ActionW-1:0] act,
                                                       input step_row_t r);
    logic [ActionW-1:0] cmp_act;
    cmp_act = r.rising ? ActWaitCmpHigh : ActWaitCmpLow;
    case (act)
      ActWaitPreScan: next_action_f = r.adc ? ActStartAdc : cmp_act;
      ActStartAdc:    next_action_f = cmp_act;
      ActWaitCmpHigh: next_action_f = ActIntegrity;
      ActWaitCmpLow:  next_action_f = ActIntegrity;
      ActIntegrity:   next_action_f = r.rpm ? ActRpmLimit : ActWaitComm;
      ActRpmLimit:    next_action_f = ActWaitComm;
      ActWaitComm:    next_action_f = ActCommutate;
      ActCommutate:   next_action_f = r.temp ? ActTempCheck : ActNextTiming;
      ActTempCheck:   next_action_f = ActNextTiming;
      ActNextTiming:  next_action_f = ActRun6Start;
      ActRun6Start:   next_action_f = ActRun6Init;
      ActRun6Init:    next_action_f = ActRun6Stop;
      default:        next_action_f = ActWaitPreScan;
    endcase
  endfunction

  function automatic logic is_final_action_f(input logic [ActionW-1:0] act,
                                             input step_row_t r);
    return (act == ActRun6Stop) || ((act == ActNextTiming) && !r.run6);
  endfunction

endpackage

// File: hdl/bldc_six_step_commutation_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bldc_six_step_commutation_sequencer
// Sensorless six-step commutation sequencer with a decoupled action generator.
// ----------------------------------------------------------------------------
// An input item is taken whenever the job queue (JobQueueDepth entries) has
// room; the front updates step and demag metric at once and queues one job.
// The back emits one result item per cycle while the output register is free
// or being popped: a begin or a sync-lost item gives one result, a commutation
// event gives six to eleven (eleven on step 6), so sustained throughput is set
// by the back's action walk at one result item per clock while it drains.
// The result item sits in an output register; the back holds while it waits
// to be popped and moves on as that register drains. The demag off
// threshold register is stored but has no effect on results.
module bldc_six_step_commutation_sequencer #(
  parameter int unsigned JobQueueDepth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          push,
  output logic                          full,
  input  logic                          operation_i,
  input  logic                          zc_timeout_i,
  input  logic                          demag_seen_i,
  input  logic                          brake_active_i,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsc_pkg::MetricW-1:0]   cfg_data_i,
  // result items
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    run_result_o,
  output logic [bsc_pkg::ActionW-1:0]   action_o,
  output logic [bsc_pkg::StepW-1:0]     cur_step_o,
  output logic [bsc_pkg::StepW-1:0]     following_step_o,
  output logic [bsc_pkg::PhaseW-1:0]    power_phase_o,
  output logic [bsc_pkg::PhaseW-1:0]    pwm_phase_out_o,
  output logic [bsc_pkg::PhaseW-1:0]    sense_phase_o,
  output logic                          cmp_rising_o,
  output logic [bsc_pkg::MetricW-1:0]   demag_level_o,
  output logic                          last_o
);

  logic                        accept;
  logic                        q_full, q_empty, q_rd;
  bsc_pkg::job_t               front_job, back_job;
  logic                        out_valid;
  logic [bsc_pkg::MetricW-1:0] demag_off_threshold;

  assign accept      = push && !q_full;
  assign full        = q_full;
  assign cfg_ready_o = 1'b1;

  bsc_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .accept_i              (accept),
    .operation_i           (operation_i),
    .zc_timeout_i          (zc_timeout_i),
    .demag_seen_i          (demag_seen_i),
    .brake_active_i        (brake_active_i),
    .cfg_write_i           (cfg_valid_i && cfg_ready_o),
    .cfg_data_i            (cfg_data_i),
    .demag_off_threshold_o (demag_off_threshold),
    .job_o                 (front_job)
  );

  bsc_job_queue #(
    .Depth (JobQueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_job_i (front_job),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .empty_o  (q_empty),
    .rd_job_o (back_job)
  );

  bsc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_empty_i      (q_empty),
    .job_i            (back_job),
    .job_rd_o         (q_rd),
    .pop_i            (pop),
    .out_valid_o      (out_valid),
    .run_result_o     (run_result_o),
    .action_o         (action_o),
    .cur_step_o       (cur_step_o),
    .following_step_o (following_step_o),
    .power_phase_o    (power_phase_o),
    .pwm_phase_out_o  (pwm_phase_out_o),
    .sense_phase_o    (sense_phase_o),
    .cmp_rising_o     (cmp_rising_o),
    .demag_level_o    (demag_level_o),
    .last_o           (last_o)
  );

  assign empty = !out_valid;

endmodule

// File: hdl/bsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_front
// Accepts input items, keeps step and demag metric, classifies each item.
// ----------------------------------------------------------------------------
module bsc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           operation_i,
  input  logic                           zc_timeout_i,
  input  logic                           demag_seen_i,
  input  logic                           brake_active_i,
  input  logic                           cfg_write_i,
  input  logic [bsc_pkg::MetricW-1:0]    cfg_data_i,
  output logic [bsc_pkg::MetricW-1:0]    demag_off_threshold_o,
  output bsc_pkg::job_t                  job_o
);

  logic [bsc_pkg::StepW-1:0]   step_q, step_d;
  logic [bsc_pkg::MetricW-1:0] metric_q, metric_d;
  logic [bsc_pkg::MetricW-1:0] threshold_q;
  logic [10:0]                 metric_acc;
  logic [bsc_pkg::MetricW-1:0] metric_new;
  bsc_pkg::step_row_t          row;
  logic                        sync_lost;

  assign row        = bsc_pkg::step_row_f(step_q);
  assign metric_acc = 11'(metric_q) * 11'd7 + (demag_seen_i ? 11'd255 : 11'd0);
  assign metric_new = (metric_acc[10:3] < bsc_pkg::MetricFloor) ?
                      bsc_pkg::MetricFloor : metric_acc[10:3];
  assign sync_lost  = zc_timeout_i && !brake_active_i && !demag_seen_i;

  always_comb begin
    step_d   = step_q;
    metric_d = metric_q;
    job_o    = '{bsc_pkg::ResRunBegun, bsc_pkg::FirstStep, bsc_pkg::FirstStep,
                 bsc_pkg::MetricFloor};
    if (operation_i == bsc_pkg::OpBegin) begin
      step_d   = bsc_pkg::FirstStep;
      metric_d = bsc_pkg::MetricFloor;
    end else if (sync_lost) begin
      metric_d = metric_new;
      job_o    = '{bsc_pkg::ResSyncLost, step_q, step_q, metric_new};
    end else begin
      metric_d = metric_new;
      step_d   = row.next;
      job_o    = '{bsc_pkg::ResCommutated, step_q, row.next, metric_new};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= bsc_pkg::FirstStep;
      metric_q    <= bsc_pkg::MetricFloor;
      threshold_q <= '0;
    end else begin
      if (accept_i) begin
        step_q   <= step_d;
        metric_q <= metric_d;
      end
      if (cfg_write_i) begin
        threshold_q <= cfg_data_i;
      end
    end
  end

  assign demag_off_threshold_o = threshold_q;

endmodule

// File: hdl/bsc_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_job_queue
// Small first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module bsc_job_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  bsc_pkg::job_t wr_job_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          empty_o,
  output bsc_pkg::job_t rd_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bsc_pkg::job_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o   = (count_q == CntW'(Depth));
  assign empty_o  = (count_q == '0);
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (rd_i) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + CntW'(1);
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: hdl/bsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_back
// Walks the action run of each job and holds the result item for the consumer.
// ----------------------------------------------------------------------------
module bsc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_empty_i,
  input  bsc_pkg::job_t                 job_i,
  output logic                          job_rd_o,
  input  logic                          pop_i,
  output logic                          out_valid_o,
  output logic [1:0]                    run_result_o,
  output logic [bsc_pkg::ActionW-1:0]   action_o,
  output logic [bsc_pkg::StepW-1:0]     cur_step_o,
  output logic [bsc_pkg::StepW-1:0]     following_step_o,
  output logic [bsc_pkg::PhaseW-1:0]    power_phase_o,
  output logic [bsc_pkg::PhaseW-1:0]    pwm_phase_out_o,
  output logic [bsc_pkg::PhaseW-1:0]    sense_phase_o,
  output logic                          cmp_rising_o,
  output logic [bsc_pkg::MetricW-1:0]   demag_level_o,
  output logic                          last_o
);

  logic                        busy_q;
  bsc_pkg::job_t               job_q;
  logic [bsc_pkg::ActionW-1:0] act_q;
  logic                        out_valid_q;

  logic                        advance, emit;
  bsc_pkg::job_t               sel_job;
  logic [bsc_pkg::ActionW-1:0] sel_act;
  bsc_pkg::step_row_t          sel_row;
  logic                        sel_last;

  // output register free or being drained this cycle
  assign advance  = !out_valid_q || pop_i;
  assign job_rd_o = advance && !busy_q && !job_empty_i;
  assign emit     = advance && (busy_q || !job_empty_i);

  assign sel_job  = busy_q ? job_q : job_i;
  assign sel_act  = busy_q ? act_q : bsc_pkg::ActWaitPreScan;
  assign sel_row  = bsc_pkg::step_row_f(sel_job.cur_step);
  assign sel_last = (sel_job.kind != bsc_pkg::ResCommutated) ||
                    bsc_pkg::is_final_action_f(sel_act, sel_row);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
      if (emit) begin
        busy_q <= !sel_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      job_q            <= sel_job;
      act_q            <= bsc_pkg::next_action_f(sel_act, sel_row);
      run_result_o     <= sel_job.kind;
      action_o         <= sel_act;
      cur_step_o       <= sel_job.cur_step;
      following_step_o <= sel_job.follow_step;
      power_phase_o    <= sel_row.power;
      pwm_phase_out_o  <= sel_row.pwm;
      sense_phase_o    <= sel_row.sense;
      cmp_rising_o     <= sel_row.rising;
      demag_level_o    <= sel_job.level;
      last_o           <= sel_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: tb/tb_bldc_six_step_commutation_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bldc_six_step_commutation_sequencer
// Self-checking bench for the six-step commutation sequencer. A directed table
// covers begin, sync-lost and every step's action run. Random begin/event
// bursts follow with idle and backpressure on both queue-style ports. Each
// result is checked against a step and demag predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_bldc_six_step_commutation_sequencer;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned SettleCycles  = 30;
  localparam int unsigned MaxReported   = 10;

  localparam int unsigned DecayMul    = 7;
  localparam int unsigned DecayShift  = 3;
  localparam int unsigned DemagWeight = 255;

  typedef struct packed {
    logic [bsc_pkg::PhaseW-1:0] power;
    logic [bsc_pkg::PhaseW-1:0] pwm;
    logic [bsc_pkg::PhaseW-1:0] sense;
    logic                       rising;
    logic [bsc_pkg::StepW-1:0]  next;
    logic                       adc;
    logic                       rpm;
    logic                       temp;
    logic                       run6;
  } phase_row_t;

  typedef struct packed {
    bsc_pkg::run_result_e        kind;
    logic [bsc_pkg::ActionW-1:0] act;
    logic [bsc_pkg::StepW-1:0]   cur;
    logic [bsc_pkg::StepW-1:0]   nxt;
    logic [bsc_pkg::PhaseW-1:0]  power;
    logic [bsc_pkg::PhaseW-1:0]  pwm;
    logic [bsc_pkg::PhaseW-1:0]  sense;
    logic                        rising;
    logic [bsc_pkg::MetricW-1:0] level;
    logic                        last;
  } result_item_t;

  typedef struct packed {
    logic         op;
    logic         zc;
    logic         dm;
    logic         br;
    logic         typed;
    result_item_t want;
  } directed_row_t;

  // step 1 drives B, pwm on C, senses A rising
  localparam result_item_t RunBegunItem =
    '{bsc_pkg::ResRunBegun, bsc_pkg::ActWaitPreScan, 3'd1, 3'd1, 2'd1, 2'd2, 2'd0,
      1'b1, 8'd120, 1'b1};
  localparam result_item_t SyncLostAtStart =
    '{bsc_pkg::ResSyncLost, bsc_pkg::ActWaitPreScan, 3'd1, 3'd1, 2'd1, 2'd2, 2'd0,
      1'b1, 8'd120, 1'b1};
  localparam result_item_t Predicted =
    '{bsc_pkg::ResCommutated, bsc_pkg::ActWaitPreScan, 3'd0, 3'd0, 2'd0, 2'd0, 2'd0,
      1'b0, 8'd0, 1'b0};

  localparam int unsigned NumDirected = 21;
  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{bsc_pkg::OpBegin, 1'b0, 1'b0, 1'b0, 1'b1, RunBegunItem},
    '{bsc_pkg::OpEvent, 1'b1, 1'b0, 1'b0, 1'b1, SyncLostAtStart},
    '{bsc_pkg::OpEvent, 1'b0, 1'b0, 1'b0, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b1, 1'b1, 1'b0, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b1, 1'b0, 1'b1, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b1, 1'b1, 1'b1, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b0, 1'b1, 1'b0, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b0, 1'b0, 1'b1, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b0, 1'b1, 1'b1, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b1, 1'b0, 1'b0, 1'b0, Predicted},
    '{bsc_pkg::OpBegin, 1'b1, 1'b1, 1'b1, 1'b1, RunBegunItem},
    '{bsc_pkg::OpEvent, 1'b0, 1'b1, 1'b0, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b0, 1'b1, 1'b0, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b0, 1'b1, 1'b0, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b1, 1'b0, 1'b0, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b0, 1'b1, 1'b0, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b0, 1'b1, 1'b0, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b0, 1'b1, 1'b0, 1'b0, Predicted},
    '{bsc_pkg::OpEvent, 1'b0, 1'b1, 1'b0, 1'b0, Predicted},
    '{bsc_pkg::OpBegin, 1'b0, 1'b0, 1'b0, 1'b1, RunBegunItem},
    '{bsc_pkg::OpEvent, 1'b0, 1'b0, 1'b0, 1'b0, Predicted}
  };

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        push           = 1'b0;
  logic                        full;
  logic                        operation_i    = 1'b0;
  logic                        zc_timeout_i   = 1'b0;
  logic                        demag_seen_i   = 1'b0;
  logic                        brake_active_i = 1'b0;
  logic                        cfg_valid_i    = 1'b0;
  logic                        cfg_ready_o;
  logic [bsc_pkg::MetricW-1:0] cfg_data_i     = '0;
  logic                        empty;
  logic                        pop            = 1'b0;
  logic [1:0]                  run_result_o;
  logic [bsc_pkg::ActionW-1:0] action_o;
  logic [bsc_pkg::StepW-1:0]   cur_step_o;
  logic [bsc_pkg::StepW-1:0]   following_step_o;
  logic [bsc_pkg::PhaseW-1:0]  power_phase_o;
  logic [bsc_pkg::PhaseW-1:0]  pwm_phase_out_o;
  logic [bsc_pkg::PhaseW-1:0]  sense_phase_o;
  logic                        cmp_rising_o;
  logic [bsc_pkg::MetricW-1:0] demag_level_o;
  logic                        last_o;

  bldc_six_step_commutation_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .operation_i     (operation_i),
    .zc_timeout_i    (zc_timeout_i),
    .demag_seen_i    (demag_seen_i),
    .brake_active_i  (brake_active_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .empty           (empty),
    .pop             (pop),
    .run_result_o    (run_result_o),
    .action_o        (action_o),
    .cur_step_o      (cur_step_o),
    .following_step_o(following_step_o),
    .power_phase_o   (power_phase_o),
    .pwm_phase_out_o (pwm_phase_out_o),
    .sense_phase_o   (sense_phase_o),
    .cmp_rising_o    (cmp_rising_o),
    .demag_level_o   (demag_level_o),
    .last_o          (last_o)
  );

  // bench copy of the sequencer state
  logic [bsc_pkg::StepW-1:0]   sim_step   = bsc_pkg::FirstStep;
  logic [bsc_pkg::MetricW-1:0] sim_metric = bsc_pkg::MetricFloor;

  result_item_t awaited_items [$];
  int unsigned  fail_count   = 0;
  int unsigned  cycle_count  = 0;
  int unsigned  tx_idle_pct  = 0;
  int unsigned  rx_idle_pct  = 0;
  bit           hold_request = 1'b0;

  initial begin
    forever begin
      #(ClkPeriod / 2) clk_i = ~clk_i;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic phase_row_t phase_row(input logic [bsc_pkg::StepW-1:0] step);
    phase_row_t r;
    case (step)
      3'd2:    r = '{2'd0, 2'd2, 2'd1, 1'b0, 3'd3, 1'b0, 1'b1, 1'b0, 1'b0};
      3'd3:    r = '{2'd0, 2'd1, 2'd2, 1'b1, 3'd4, 1'b0, 1'b0, 1'b0, 1'b0};
      3'd4:    r = '{2'd2, 2'd1, 2'd0, 1'b0, 3'd5, 1'b0, 1'b0, 1'b0, 1'b0};
      3'd5:    r = '{2'd2, 2'd0, 2'd1, 1'b1, 3'd6, 1'b0, 1'b0, 1'b0, 1'b0};
      3'd6:    r = '{2'd1, 2'd0, 2'd2, 1'b0, 3'd1, 1'b1, 1'b0, 1'b1, 1'b1};
      default: r = '{2'd1, 2'd2, 2'd0, 1'b1, 3'd2, 1'b0, 1'b0, 1'b0, 1'b0};
    endcase
    return r;
  endfunction

  function automatic result_item_t fill_item(input bsc_pkg::run_result_e kind,
                                             input logic [bsc_pkg::ActionW-1:0] act,
                                             input logic [bsc_pkg::StepW-1:0] cur,
                                             input logic [bsc_pkg::StepW-1:0] nxt,
                                             input phase_row_t r);
    result_item_t it;
    it = '{kind, act, cur, nxt, r.power, r.pwm, r.sense, r.rising, sim_metric, 1'b0};
    return it;
  endfunction

  // step/metric update for one accepted item, returns its result run
  function automatic void predict_commutation(input logic op, input logic zc,
                                              input logic dm, input logic br,
                                              output result_item_t items [$]);
    phase_row_t                  r;
    result_item_t                it;
    logic [10:0]                 acc;
    logic [bsc_pkg::ActionW-1:0] acts [$];
    items = {};
    if (op == bsc_pkg::OpBegin) begin
      sim_step   = bsc_pkg::FirstStep;
      sim_metric = bsc_pkg::MetricFloor;
      it = fill_item(bsc_pkg::ResRunBegun, bsc_pkg::ActWaitPreScan, bsc_pkg::FirstStep,
                     bsc_pkg::FirstStep, phase_row(bsc_pkg::FirstStep));
      it.last = 1'b1;
      items.push_back(it);
      return;
    end
    acc = {3'b0, sim_metric} * 11'(DecayMul) + (dm ? 11'(DemagWeight) : 11'd0);
    acc = acc >> DecayShift;
    if (acc < 11'(bsc_pkg::MetricFloor)) acc = 11'(bsc_pkg::MetricFloor);
    sim_metric = acc[bsc_pkg::MetricW-1:0];
    r = phase_row(sim_step);
    // timeout only counts as lost sync when nothing else explains it
    if (zc && !br && !dm) begin
      it = fill_item(bsc_pkg::ResSyncLost, bsc_pkg::ActWaitPreScan, sim_step, sim_step, r);
      it.last = 1'b1;
      items.push_back(it);
      return;
    end
    acts.push_back(bsc_pkg::ActWaitPreScan);
    if (r.adc) acts.push_back(bsc_pkg::ActStartAdc);
    acts.push_back(r.rising ? bsc_pkg::ActWaitCmpHigh : bsc_pkg::ActWaitCmpLow);
    acts.push_back(bsc_pkg::ActIntegrity);
    if (r.rpm) acts.push_back(bsc_pkg::ActRpmLimit);
    acts.push_back(bsc_pkg::ActWaitComm);
    acts.push_back(bsc_pkg::ActCommutate);
    if (r.temp) acts.push_back(bsc_pkg::ActTempCheck);
    acts.push_back(bsc_pkg::ActNextTiming);
    if (r.run6) begin
      acts.push_back(bsc_pkg::ActRun6Start);
      acts.push_back(bsc_pkg::ActRun6Init);
      acts.push_back(bsc_pkg::ActRun6Stop);
    end
    foreach (acts[i]) begin
      it = fill_item(bsc_pkg::ResCommutated, acts[i], sim_step, r.next, r);
      it.last = (i == acts.size() - 1);
      items.push_back(it);
    end
    sim_step = r.next;
  endfunction

  function automatic string describe(input result_item_t it);
    return $sformatf("kind %0d act %0d step %0d->%0d ph %0d/%0d/%0d rise %0b lvl %0d last %0b",
                     it.kind, it.act, it.cur, it.nxt, it.power, it.pwm, it.sense,
                     it.rising, it.level, it.last);
  endfunction

  // returns once the item transfer has happened
  task automatic send_item(input logic op, input logic zc, input logic dm, input logic br);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    operation_i    <= op;
    zc_timeout_i   <= zc;
    demag_seen_i   <= dm;
    brake_active_i <= br;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_predicted(input logic op, input logic zc, input logic dm,
                                input logic br);
    result_item_t items [$];
    send_item(op, zc, dm, br);
    predict_commutation(op, zc, dm, br, items);
    foreach (items[i]) awaited_items.push_back(items[i]);
  endtask

  task automatic write_threshold(input logic [bsc_pkg::MetricW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (awaited_items.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    result_item_t items [$];
    foreach (DirectedRows[i]) begin
      send_item(DirectedRows[i].op, DirectedRows[i].zc, DirectedRows[i].dm,
                DirectedRows[i].br);
      predict_commutation(DirectedRows[i].op, DirectedRows[i].zc, DirectedRows[i].dm,
                          DirectedRows[i].br, items);
      if (DirectedRows[i].typed) begin
        awaited_items.push_back(DirectedRows[i].want);
      end else begin
        foreach (items[k]) awaited_items.push_back(items[k]);
      end
    end
  endtask

  // bursts of events, most led by a begin, demag rate set per burst
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst_len;
    int unsigned demag_pct;
    int unsigned zc_pct;
    int unsigned brake_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        send_predicted(bsc_pkg::OpBegin, 1'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end
      burst_len = $urandom_range(4, 40);
      case ($urandom_range(2))
        0:       demag_pct = 5;
        1:       demag_pct = 40;
        default: demag_pct = 95;
      endcase
      zc_pct    = $urandom_range(10, 60);
      brake_pct = $urandom_range(0, 40);
      for (int unsigned k = 0; k < burst_len && sent < n_items; k++) begin
        send_predicted(bsc_pkg::OpEvent, $urandom_range(99) < zc_pct,
                       $urandom_range(99) < demag_pct, $urandom_range(99) < brake_pct);
        sent++;
      end
    end
  endtask

  initial begin : result_sink
    int unsigned  hold_count;
    bit           hold_done;
    result_item_t seen;
    result_item_t want;
    hold_count = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        seen = {run_result_o, action_o, cur_step_o, following_step_o, power_phase_o,
                pwm_phase_out_o, sense_phase_o, cmp_rising_o, demag_level_o, last_o};
        if (awaited_items.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReported) begin
            $display("unexpected result: %s", describe(seen));
          end
        end else begin
          want = awaited_items.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= MaxReported) begin
              $display("result mismatch at cycle %0d", cycle_count);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(seen));
            end
          end
        end
      end
      // long hold-off lets the job queue fill and back up the input side
      if (hold_request && !hold_done) begin
        pop <= 1'b0;
        hold_count++;
        if (hold_count >= HoldOffCycles) hold_done = 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_threshold(8'hFF);

    tx_idle_pct = 23;
    rx_idle_pct = 67;
    run_directed();
    drain_results();
    write_threshold(8'h00);
    run_random(100);
    drain_results();

    write_threshold(8'($urandom_range(1, 254)));
    tx_idle_pct = 67;
    rx_idle_pct = 23;
    run_random(100);
    drain_results();

    write_threshold(8'($urandom_range(1, 254)));
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = 1'b1;
    run_random(100);
    drain_results();

    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && awaited_items.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
